FILE: rtl/vtp_pkg.sv
// vtp_pkg: command codes, field widths and sequencer states for the virtual timer pool.
// No dependencies; compiled first.
`default_nettype none

package vtp_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned HANDLE_W  = 4;
  localparam int unsigned ELAPSED_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_READ    = 3'd3,
    CMD_FREE    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MEM,
    ST_CALC,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/vtp_cmd_if.sv
// vtp_cmd_if / vtp_rsp_if: valid/ready channels for commands and responses.
// Depends on vtp_pkg for field widths.
`default_nettype none

interface vtp_cmd_if;
  import vtp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output cmd, output handle, input ready);
  modport sink   (input valid, input cmd, input handle, output ready);
endinterface

interface vtp_rsp_if;
  import vtp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [HANDLE_W-1:0]  handle_out;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, output ok, output handle_out, output elapsed, input ready);
  modport sink   (input valid, input ok, input handle_out, input elapsed, output ready);
endinterface

`default_nettype wire

FILE: rtl/virtual_timer_pool.sv
// virtual_timer_pool: pool of virtual timers sharing one wrapping tick counter.
// Depends on vtp_pkg and the vtp_cmd_if / vtp_rsp_if interfaces.
`default_nettype none

// A pool of NUM_TIMERS virtual timers that share one wrapping TICK_WIDTH-bit
// tick counter advanced by tick commands. Each command transfer (tick, allocate,
// restart, read elapsed, free) produces exactly one response transfer.
// Allocate hands out the lowest free timer, searching from timer 0; when
// none is free, ok is 0. Read returns the count minus the start count
// recorded by restart, modulo 2^TICK_WIDTH, in the low 16 bits of elapsed.
// Handles at or above NUM_TIMERS are ignored by restart and free, and read
// 0. Codes 5 to 7 change nothing and respond ok=1 with zero fields.
// Timing: one command at a time, with a small sequencer driving one shared
// adder, a one-flag-per-cycle free-timer scan and a start-count memory with
// registered read. Tick, restart, free and unknown codes go through ST_CALC
// and ST_DONE; read goes through ST_MEM, ST_CALC and ST_DONE; allocate goes
// through ST_SCAN, from timer 0 to the first free or the last timer, and then
// ST_DONE. The response sits in an output register, so a new command is taken
// while the previous response still waits.
module virtual_timer_pool #(
  parameter int unsigned NUM_TIMERS = 12,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  vtp_cmd_if.sink    cmd_if_i,
  vtp_rsp_if.source  rsp_if_o
);
  import vtp_pkg::*;

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  // sequencer
  state_e state_q, state_d;

  // latched command
  cmd_e             cmd_q;
  logic [IDX_W-1:0] hidx_q;
  logic             in_range_q;

  // timer state
  logic [TICK_WIDTH-1:0] tick_q;
  logic [NUM_TIMERS-1:0] busy_q;
  logic [NUM_TIMERS-1:0] start_vld_q;   // entry written since reset
  logic [TICK_WIDTH-1:0] start_mem [NUM_TIMERS];
  logic [TICK_WIDTH-1:0] rd_data_q;
  logic                  rd_vld_q;

  // free-timer scan
  logic [IDX_W-1:0] scan_q, scan_d;

  // pending result
  logic                 res_ok_q, res_ok_d;
  logic [HANDLE_W-1:0]  res_hout_q, res_hout_d;
  logic [ELAPSED_W-1:0] res_elap_q, res_elap_d;

  // output register
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [HANDLE_W-1:0]  out_hout_q;
  logic [ELAPSED_W-1:0] out_elap_q;

  // shared adder
  logic [TICK_WIDTH-1:0] alu_a, alu_b, alu_sum;
  logic                  alu_cin;

  // control
  logic                  accept;
  logic                  out_load;
  logic                  tick_we;
  logic                  mem_we;
  logic                  busy_set;
  logic                  busy_clr;
  logic [TICK_WIDTH-1:0] start_val;

  assign accept   = cmd_if_i.valid && cmd_if_i.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp_if_o.ready);

  assign cmd_if_i.ready = (state_q == ST_IDLE);

  assign rsp_if_o.valid      = out_valid_q;
  assign rsp_if_o.ok         = out_ok_q;
  assign rsp_if_o.handle_out = out_hout_q;
  assign rsp_if_o.elapsed    = out_elap_q;

  // never-written entries read as zero
  assign start_val = rd_vld_q ? rd_data_q : '0;

  assign alu_sum = alu_a + alu_b + TICK_WIDTH'(alu_cin);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_if_i.cmd))
            CMD_ALLOC: state_d = ST_SCAN;
            CMD_READ:  state_d = ST_MEM;
            default:   state_d = ST_CALC;
          endcase
        end
      end
      ST_SCAN: begin
        if (!busy_q[scan_q] || scan_q == LAST_IDX) begin
          state_d = ST_DONE;
        end
      end
      ST_MEM:  state_d = ST_CALC;
      ST_CALC: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    scan_d     = scan_q;
    res_ok_d   = res_ok_q;
    res_hout_d = res_hout_q;
    res_elap_d = res_elap_q;
    alu_a      = tick_q;
    alu_b      = '0;
    alu_cin    = 1'b1;
    tick_we    = 1'b0;
    mem_we     = 1'b0;
    busy_set   = 1'b0;
    busy_clr   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_d     = '0;
          res_ok_d   = 1'b1;
          res_hout_d = '0;
          res_elap_d = '0;
        end
      end
      ST_SCAN: begin
        if (!busy_q[scan_q]) begin
          busy_set   = 1'b1;
          res_hout_d = HANDLE_W'(scan_q);
        end else if (scan_q == LAST_IDX) begin
          res_ok_d = 1'b0;        // pool full
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_CALC: begin
        case (cmd_q)
          CMD_TICK: begin
            tick_we = 1'b1;       // tick + 0 + 1
          end
          CMD_RESTART: begin
            mem_we = in_range_q;
          end
          CMD_READ: begin
            alu_b = ~start_val;   // tick - start
            if (in_range_q) begin
              res_elap_d = ELAPSED_W'(alu_sum);
            end
          end
          CMD_FREE: begin
            busy_clr = in_range_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      busy_q      <= '0;
      start_vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tick_we) begin
        tick_q <= alu_sum;
      end
      if (busy_set) begin
        busy_q[scan_q] <= 1'b1;
      end
      if (busy_clr) begin
        busy_q[hidx_q] <= 1'b0;
      end
      if (mem_we) begin
        start_vld_q[hidx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(cmd_if_i.cmd);
      hidx_q     <= IDX_W'(cmd_if_i.handle);
      in_range_q <= (7'(cmd_if_i.handle) < 7'(NUM_TIMERS));
    end
    scan_q     <= scan_d;
    res_ok_q   <= res_ok_d;
    res_hout_q <= res_hout_d;
    res_elap_q <= res_elap_d;
    if (out_load) begin
      out_ok_q   <= res_ok_q;
      out_hout_q <= res_hout_q;
      out_elap_q <= res_elap_q;
    end
  end

  // start-count memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      start_mem[hidx_q] <= tick_q;
    end
    rd_data_q <= start_mem[hidx_q];
    rd_vld_q  <= start_vld_q[hidx_q] && in_range_q;
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench: self-checking bench for virtual_timer_pool, with a built-in model of
// the tick counter, start counts and busy flags. Depends on vtp_pkg and the
// vtp_cmd_if / vtp_rsp_if interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vtp_pkg::*;

  localparam int unsigned NUM_TIMERS  = 12;
  localparam int unsigned TICK_WIDTH  = 16;
  // Longest run of cycles with no transfer on either channel before we give up.
  // The slowest command is a full-pool allocate, which scans every timer; the
  // long response hold-off below is set by HOLD_CYCLES.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  // Quiet time after the last response, a few times the slowest command.
  localparam int unsigned SETTLE_CYCLES = 4 * NUM_TIMERS;
  localparam int unsigned HANDLE_MAX  = (1 << HANDLE_W) - 1;

  // Codes past CMD_FREE are unassigned; the block must answer them with a
  // plain ok and touch nothing.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = CMD_W'(CMD_FREE + 1);
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = '1;

  typedef struct packed {
    logic                 ok;
    logic [HANDLE_W-1:0]  handle_out;
    logic [ELAPSED_W-1:0] elapsed;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vtp_cmd_if cmd_if ();
  vtp_rsp_if rsp_if ();

  virtual_timer_pool #(
    .NUM_TIMERS(NUM_TIMERS),
    .TICK_WIDTH(TICK_WIDTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_if_i(cmd_if),
    .rsp_if_o(rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pool model: shared counter, per-timer start counts and busy flags.
  // ---------------------------------------------------------------------------
  logic [TICK_WIDTH-1:0] count_now;
  logic [TICK_WIDTH-1:0] mark [NUM_TIMERS];
  logic                  in_use [NUM_TIMERS];

  // Replies owed by the block, oldest first.
  reply_t replies_due [$];

  int unsigned failures;
  int unsigned quiet_cycles;
  int unsigned send_gap_pct;   // chance in 100 of a gap before each command
  int unsigned take_gap_pct;   // chance in 100 that response ready is low
  int unsigned hold_off;       // cycles left of a forced response stall

  function automatic void clear_pool();
    count_now = '0;
    foreach (mark[i]) begin
      mark[i]   = '0;
      in_use[i] = 1'b0;
    end
  endfunction

  // Applies one command to the model and returns the reply it must produce.
  function automatic reply_t pool_cmd(input logic [CMD_W-1:0] code,
                                      input logic [HANDLE_W-1:0] h);
    reply_t r;
    logic   known;
    r     = '{ok: 1'b1, handle_out: '0, elapsed: '0};
    known = (h < NUM_TIMERS);
    case (code)
      CMD_TICK: count_now = count_now + 1'b1;
      CMD_ALLOC: begin
        // lowest free timer wins; search always starts at timer 0
        r.ok = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!r.ok && !in_use[i]) begin
            in_use[i]    = 1'b1;
            r.ok         = 1'b1;
            r.handle_out = HANDLE_W'(i);
          end
        end
      end
      CMD_RESTART: if (known) mark[h] = count_now;
      CMD_READ:    if (known) r.elapsed = ELAPSED_W'(count_now - mark[h]);
      CMD_FREE:    if (known) in_use[h] = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Valid stays high from one command to the next when there is
  // no gap, so it is never dropped and raised within one time step.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [HANDLE_W-1:0] h);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.cmd    <= code;
    cmd_if.handle <= h;
    do @(posedge clk_i); while (!cmd_if.ready);
    replies_due.push_back(pool_cmd(code, h));
  endtask

  // Stop offering commands and wait for every owed reply.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // One random command. Handles are mostly in range so restart/read/free act
  // on real timers; about one in twenty is past the pool. Alloc and free rates
  // are close, so the pool wanders between empty and full.
  task automatic random_cmd();
    int unsigned         roll;
    logic [HANDLE_W-1:0] h;
    logic [HANDLE_W-1:0] h_any;
    logic [CMD_W-1:0]    rsvd;
    roll  = $urandom_range(99);
    h     = HANDLE_W'($urandom_range(NUM_TIMERS - 1));
    h_any = HANDLE_W'($urandom_range(HANDLE_MAX));
    rsvd  = CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
    if ($urandom_range(19) == 0) h = HANDLE_W'($urandom_range(HANDLE_MAX, NUM_TIMERS));
    if (roll < 30)      send_cmd(CMD_TICK, h_any);
    else if (roll < 47) send_cmd(CMD_ALLOC, h_any);
    else if (roll < 62) send_cmd(CMD_RESTART, h);
    else if (roll < 80) send_cmd(CMD_READ, h);
    else if (roll < 96) send_cmd(CMD_FREE, h);
    else send_cmd(rsvd, h_any);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: compare each transfer with the oldest owed reply, then pick
  // the next ready. A hold-off forces ready low for a counted stretch.
  // ---------------------------------------------------------------------------
  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected response: ok=%0d handle_out=%0d elapsed=%0d",
             rsp_if.ok, rsp_if.handle_out, rsp_if.elapsed);
      failures++;
    end else begin
      want = replies_due.pop_front();
      if (rsp_if.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
        failures++;
      end
      if (rsp_if.handle_out !== want.handle_out) begin
        $error("handle_out: expected %0d, got %0d", want.handle_out, rsp_if.handle_out);
        failures++;
      end
      if (rsp_if.elapsed !== want.elapsed) begin
        $error("elapsed: expected %0d, got %0d", want.elapsed, rsp_if.elapsed);
        failures++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rsp_if.valid === 1'b1 && rsp_if.ready) check_reply();
    if (hold_off != 0) begin
      rsp_if.ready <= 1'b0;
      hold_off     <= hold_off - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked commands: basic timing, filling the pool to overflow, freeing
  // a timer twice, handles past the pool, and the unassigned codes.
  task automatic test_directed();
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_RESTART, HANDLE_W'(0));       // timer 0 starts at count 1
    send_cmd(CMD_TICK, HANDLE_W'(HANDLE_MAX));
    send_cmd(CMD_READ, HANDLE_W'(0));          // one tick since restart
    for (int i = 0; i < NUM_TIMERS; i++) send_cmd(CMD_ALLOC, HANDLE_W'(HANDLE_MAX));
    send_cmd(CMD_ALLOC, '0);                   // pool full, ok low
    send_cmd(CMD_FREE, HANDLE_W'(5));
    send_cmd(CMD_FREE, HANDLE_W'(5));          // already free, stays free
    send_cmd(CMD_ALLOC, '0);                   // lowest free is 5 again
    send_cmd(CMD_RESTART, HANDLE_W'(HANDLE_MAX)); // past the pool, ignored
    send_cmd(CMD_READ, HANDLE_W'(HANDLE_MAX));    // past the pool, reads zero
    send_cmd(CMD_FREE, HANDLE_W'(NUM_TIMERS));    // past the pool, ignored
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
      send_cmd(CMD_W'(c), HANDLE_W'(HANDLE_MAX));
    end
    send_cmd(CMD_READ, HANDLE_W'(NUM_TIMERS - 1)); // never restarted, counts from 0
    drain();
  endtask

  // Random traffic under one idling pattern.
  task automatic test_random(input int unsigned n, input int unsigned send_pct,
                             input int unsigned take_pct);
    send_gap_pct = send_pct;
    take_gap_pct <= take_pct;
    repeat (n) random_cmd();
    drain();
  endtask

  // The receiver stalls for a long stretch while commands keep coming, so the
  // output register fills and the block must hold off the command channel.
  task automatic test_backpressure();
    send_gap_pct = 0;
    take_gap_pct <= 0;
    hold_off     <= HOLD_CYCLES;
    repeat (20) random_cmd();
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = CMD_TICK;
    cmd_if.handle = '0;
    rsp_if.ready  = 1'b0;
    failures      = 0;
    quiet_cycles  = 0;
    hold_off      = 0;
    send_gap_pct  = 6;
    take_gap_pct  = 83;
    clear_pool();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cases, slow receiver, slow sender, long receiver stall, no idling
    test_directed();
    test_random(470, 6, 83);
    test_random(470, 83, 6);
    test_backpressure();
    test_random(470, 0, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
